// File: rtl/nps_pkg.sv
// Shared constants and command/status types for the nearest point selector.
`default_nettype none

package nps_pkg;

   localparam int MAX_SINKS = 64;
   localparam int COORD_W   = 16;
   localparam int IDX_W     = $clog2(MAX_SINKS);
   localparam int CNT_W     = 7;
   localparam int SLOT_W    = 6;
   localparam int ABS_W     = COORD_W;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = 2 * COORD_W + 2;
   localparam int ENTRY_W   = 3 * COORD_W;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic             mem_we;
      logic             src_load;
      logic             issue;
      logic [IDX_W-1:0] addr;
      logic             out_load;
   } nps_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_busy;
   } nps_status_type;

endpackage

`default_nettype wire

// File: rtl/nps_datapath.sv
// Sink table, distance pipeline, running minimum and result register.
`default_nettype none

module nps_datapath
   import nps_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nps_cmd_type                cmd,
   output      nps_status_type             status,
   input  wire logic        [SLOT_W-1:0]   slot,
   input  wire logic signed [COORD_W-1:0]  pos_x,
   input  wire logic signed [COORD_W-1:0]  pos_y,
   input  wire logic signed [COORD_W-1:0]  pos_z,
   output      logic        [IDX_W-1:0]    nearest
);

   function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic        [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[ABS_W-1:0];
   endfunction

   logic [ENTRY_W-1:0] mem [MAX_SINKS];

   logic signed [COORD_W-1:0] src_x_ff, src_y_ff, src_z_ff;
   logic [ENTRY_W-1:0]        rd_ff;
   logic [ABS_W-1:0]          abs_x_ff, abs_y_ff, abs_z_ff;
   logic [SQ_W-1:0]           sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_W-1:0]         sum_ff;
   logic [DIST_W-1:0]         best_dist_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [IDX_W-1:0]          idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [3:0]                v_ff, v_in;
   logic [IDX_W-1:0]          nearest_ff;
   logic                      take_best;

   // table write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[slot[IDX_W-1:0]] <= {pos_x, pos_y, pos_z};
      end
      rd_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.src_load) begin
         src_x_ff <= pos_x;
         src_y_ff <= pos_y;
         src_z_ff <= pos_z;
      end
   end

   assign v_in = {v_ff[2:0], cmd.issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 2: absolute differences, stage 3: squares, stage 4: sum
   always_ff @(posedge clock) begin
      idx1_ff  <= cmd.addr;
      abs_x_ff <= abs_diff(src_x_ff, rd_ff[3*COORD_W-1:2*COORD_W]);
      abs_y_ff <= abs_diff(src_y_ff, rd_ff[2*COORD_W-1:COORD_W]);
      abs_z_ff <= abs_diff(src_z_ff, rd_ff[COORD_W-1:0]);
      idx2_ff  <= idx1_ff;
      sq_x_ff  <= abs_x_ff * abs_x_ff;
      sq_y_ff  <= abs_y_ff * abs_y_ff;
      sq_z_ff  <= abs_z_ff * abs_z_ff;
      idx3_ff  <= idx2_ff;
      sum_ff   <= DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);
      idx4_ff  <= idx3_ff;
   end

   // strict compare keeps the lowest index on ties; index zero seeds the search
   assign take_best = v_ff[3] && ((idx4_ff == '0) || (sum_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_dist_ff <= sum_ff;
         best_idx_ff  <= idx4_ff;
      end
      if (cmd.out_load) begin
         nearest_ff <= best_idx_ff;
      end
   end

   assign status.pipe_busy = |v_ff;
   assign nearest          = nearest_ff;

endmodule

`default_nettype wire

// File: rtl/nps_ctrl.sv
// Control state machine: handshakes, sink count register and scan sequencing.
`default_nettype none

module nps_ctrl
   import nps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_opcode,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              csr_write_en,
   input  wire logic [CNT_W-1:0]  csr_write_data,
   output      nps_cmd_type       cmd,
   input  wire nps_status_type    status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] last_idx;
   logic             rsp_valid_ff, rsp_valid_in;

   // zero behaves as one, anything above the table size saturates
   always_comb begin
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (count_ff > CNT_W'(MAX_SINKS)) begin
         last_idx = IDX_W'(MAX_SINKS - 1);
      end else begin
         last_idx = IDX_W'(count_ff - 1'b1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cmd          = '0;
      cmd.addr     = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_LOCATE) begin
                  cmd.src_load = 1'b1;
                  addr_in      = '0;
                  state_in     = ST_SCAN;
               end else begin
                  cmd.mem_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (addr_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/nearest_point_selector_3d_unit.sv
// Top level of the nearest point selector: controller plus datapath.
// Load beat: written to the sink table at the accepting edge, no result.
// Locate beat: occupies the unit while it scans and drains (count clamped to 1..64);
//   the single table read port feeds one sink per cycle into a 4-stage distance pipe.
// Result leaves through an output register; a new beat is taken while it waits.
// Reset: synchronous, active high; clears control, active_sinks = 1, table undefined.
`default_nettype none

module nearest_point_selector_3d_unit
   import nps_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_opcode,
   input  wire logic        [SLOT_W-1:0]   req_sink_slot,
   input  wire logic signed [COORD_W-1:0]  req_pos_x,
   input  wire logic signed [COORD_W-1:0]  req_pos_y,
   input  wire logic signed [COORD_W-1:0]  req_pos_z,
   // response channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic        [IDX_W-1:0]    rsp_nearest_sink,
   // active sink count register
   input  wire logic                       csr_write_en,
   input  wire logic        [CNT_W-1:0]    csr_write_data
);

   nps_cmd_type    cmd;
   nps_status_type status;

   // sequencing: IDLE takes a beat, SCAN walks the table, DRAIN empties the pipe,
   // FINISH moves the winner into the output register once it is free
   nps_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status)
   );

   // table read -> |dx| -> dx^2 -> sum -> running minimum (strict, lowest index wins)
   nps_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .slot    (req_sink_slot),
      .pos_x   (req_pos_x),
      .pos_y   (req_pos_y),
      .pos_z   (req_pos_z),
      .nearest (rsp_nearest_sink)
   );

endmodule

`default_nettype wire
